FILE: hdl/bscc_pkg.sv
package bscc_pkg;

  // Map geometry.
  localparam int MAP_WORDS = 128;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W     = $clog2(MAP_WORDS + 1);
  localparam int BIT_SEL_W = $clog2(WORD_BITS);

  // Field widths.
  localparam int OP_W   = 3;
  localparam int IDX_W  = 12;
  localparam int ONES_W = 13;
  localparam int POP_W  = $clog2(WORD_BITS + 1);

  localparam logic [IDX_W-1:0] MAP_BITS_RST = 12'd4063;
  localparam logic [3:0]       NIBBLE_MASK  = 4'hf;

  typedef enum logic [OP_W-1:0] {
    OP_SET     = 3'd0,
    OP_CLR     = 3'd1,
    OP_TEST    = 3'd2,
    OP_COUNT   = 3'd3,
    OP_CLR_ALL = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COUNT
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [IDX_W-1:0] bit_index;
  } bscc_in_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] set_count;
    logic [ONES_W-1:0]  ones;
    logic               status;
  } bscc_out_t;

  // Controls for the ones accumulator.
  typedef struct packed {
    logic clr;
    logic add;
  } acc_ctl_t;

  // Ones in one nibble.
  function automatic logic [2:0] nibble_ones(input logic [3:0] n);
    logic [2:0] c;
    case (n)
      4'h0: c = 3'd0;
      4'h1, 4'h2, 4'h4, 4'h8: c = 3'd1;
      4'h3, 4'h5, 4'h6, 4'h9, 4'ha, 4'hc: c = 3'd2;
      4'h7, 4'hb, 4'hd, 4'he: c = 3'd3;
      4'hf: c = 3'd4;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  // Ones in one map word, summed nibble by nibble.
  function automatic logic [POP_W-1:0] word_ones(input logic [WORD_BITS-1:0] w);
    logic [POP_W-1:0] c;
    c = '0;
    for (int k = 0; k < WORD_BITS / 4; k++) begin
      c = c + POP_W'(nibble_ones(w[4*k +: 4] & NIBBLE_MASK));
    end
    return c;
  endfunction

  // Words in use for a capacity setting, limited to the map size.
  function automatic logic [CNT_W-1:0] words_in_use(input logic [IDX_W-1:0] mb);
    int n;
    n = int'(mb[IDX_W-1:BIT_SEL_W]) + 1;
    if (n > MAP_WORDS) begin
      n = MAP_WORDS;
    end
    return CNT_W'(n);
  endfunction

endpackage

FILE: hdl/bscc_ram.sv
module bscc_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/bscc_popacc.sv
module bscc_popacc import bscc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  acc_ctl_t             ctl,
  input  logic [WORD_BITS-1:0] word,
  output logic [ONES_W-1:0]    sum
);

  logic [ONES_W-1:0] acc_r;

  // Running total plus the ones of the current input word.
  assign sum = acc_r + ONES_W'(word_ones(word));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.add) begin
      acc_r <= sum;
    end
  end

endmodule

FILE: hdl/bitmap_set_clear_test_count_unit.sv
// Bit map of MAP_WORDS 32-bit words with set, clear, test, count and clear-all.
//
// Input channel: an item (opcode, bit_index) is taken on a clock edge where
// start is high and busy is low. Each item gives exactly one result item on
// out_item, marked by out_valid for one cycle; the receiver cannot stall it.
// Configuration: cfg_we writes cfg_wdata into the capacity register; write it
// only while the block is idle. The map contents are kept across such writes.
//
// Set and clear read the word from the map memory, then modify it and write it
// back; test only reads it, and clear-all resets the valid bits. The result
// shows in the cycle after the execute state; the next item can be taken in
// that same cycle. Count walks the words in use through the memory read port,
// one word per cycle, and shows its result once the last word has been added.
//
// Reset clears a per-word valid bit; an invalid word reads as zero, so there
// is no clearing pass. Clear-all uses the same valid bits and also zeroes the
// sets-minus-clears counter. After reset the capacity is 4063.
module bitmap_set_clear_test_count_unit import bscc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  bscc_in_t         in_item,
  output logic             out_valid,
  output bscc_out_t        out_item,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_wdata
);

  state_t                 state_r, state_nxt;
  logic [OP_W-1:0]        op_r;
  logic [IDX_W-1:0]       idx_r;
  logic [IDX_W-1:0]       map_bits_r;
  logic [31:0]            cnt_r, cnt_nxt;
  logic [MAP_WORDS-1:0]   valid_r;
  logic                   vld_q_r;
  logic [CNT_W-1:0]       cnt_addr_r, cnt_addr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  bscc_out_t              out_item_r, res_nxt;

  logic                   accept;
  logic [CNT_W-1:0]       used;
  logic                   in_range;
  logic                   clear_all;
  logic [WORD_BITS-1:0]   mask;
  logic [WORD_BITS-1:0]   rd_word;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0]   ram_wdata, ram_rdata;
  acc_ctl_t               acc_ctl;
  logic [ONES_W-1:0]      acc_sum;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign used      = words_in_use(map_bits_r);
  assign in_range  = int'(idx_r[IDX_W-1:BIT_SEL_W]) < int'(used);
  assign mask      = WORD_BITS'(1) << idx_r[BIT_SEL_W-1:0];
  assign rd_word   = vld_q_r ? ram_rdata : '0;
  assign ram_waddr = ADDR_W'(idx_r[IDX_W-1:BIT_SEL_W]);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Map memory.
  bscc_ram #(
    .DEPTH(MAP_WORDS),
    .WIDTH(WORD_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Ones accumulator for the count walk.
  bscc_popacc u_popacc (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (acc_ctl),
    .word (rd_word),
    .sum  (acc_sum)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_item.opcode == OP_COUNT) ? ST_COUNT : ST_EXEC;
        end
      end
      ST_EXEC: state_nxt = ST_IDLE;
      ST_COUNT: begin
        if (cnt_addr_r == used) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory control, write-back data and result.
  always_comb begin
    ram_raddr     = ADDR_W'(in_item.bit_index[IDX_W-1:BIT_SEL_W]);
    ram_we        = 1'b0;
    ram_wdata     = rd_word | mask;
    cnt_nxt       = cnt_r;
    cnt_addr_nxt  = cnt_addr_r;
    clear_all     = 1'b0;
    acc_ctl       = '0;
    out_valid_nxt = 1'b0;
    res_nxt       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_item.opcode == OP_COUNT) begin
          ram_raddr    = '0;
          acc_ctl.clr  = 1'b1;
          cnt_addr_nxt = CNT_W'(1);
        end
      end
      ST_EXEC: begin
        out_valid_nxt = 1'b1;
        case (op_r)
          OP_SET: begin
            if (in_range) begin
              ram_we    = 1'b1;
              ram_wdata = rd_word | mask;
              cnt_nxt   = cnt_r + 32'd1;
            end else begin
              res_nxt.status = 1'b1;
            end
          end
          OP_CLR: begin
            if (in_range) begin
              ram_we    = 1'b1;
              ram_wdata = rd_word & ~mask;
              cnt_nxt   = cnt_r - 32'd1;
            end else begin
              res_nxt.status = 1'b1;
            end
          end
          OP_TEST: begin
            if (in_range) begin
              res_nxt.found = |(rd_word & mask);
            end else begin
              res_nxt.status = 1'b1;
            end
          end
          OP_CLR_ALL: begin
            clear_all = 1'b1;
            cnt_nxt   = '0;
          end
          default: ;
        endcase
      end
      ST_COUNT: begin
        // The word read last cycle is added; the next one is read if any remain.
        ram_raddr   = cnt_addr_r[ADDR_W-1:0];
        acc_ctl.add = 1'b1;
        if (cnt_addr_r == used) begin
          out_valid_nxt = 1'b1;
          res_nxt.ones  = acc_sum;
        end else begin
          cnt_addr_nxt = cnt_addr_r + CNT_W'(1);
        end
      end
      default: ;
    endcase
    res_nxt.set_count = cnt_nxt;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      valid_r     <= '0;
      map_bits_r  <= MAP_BITS_RST;
      out_valid_r <= 1'b0;
      cnt_addr_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_addr_r  <= cnt_addr_nxt;
      if (cfg_we) begin
        map_bits_r <= cfg_wdata;
      end
      if (clear_all) begin
        valid_r <= '0;
      end else if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers. The valid bit is registered alongside the memory read data.
  always_ff @(posedge clk) begin
    vld_q_r    <= valid_r[ram_raddr];
    out_item_r <= res_nxt;
    if (accept) begin
      op_r  <= in_item.opcode;
      idx_r <= in_item.bit_index;
    end
  end

  // An accepted item always makes the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("block not busy after accepting an item");

  // A result only follows a cycle of real work.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r != ST_IDLE))
    else $error("result without a preceding execute or count cycle");

  // An out-of-range request leaves the counter untouched.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status) |-> $stable(cnt_r))
    else $error("counter changed on an out-of-range request");

  // The count walk never runs past the words in use.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COUNT) |-> (cnt_addr_r <= used))
    else $error("count walk past the words in use");

  // A nonzero ones value only comes from a count.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.ones != '0) |-> $past(state_r == ST_COUNT))
    else $error("ones reported outside a count");

endmodule
